/* hw/rtl/rem_pkg.sv */
// shared types, constants and helpers of the regression error metric block
package rem_pkg;

  // fraction bits of the input pairs
  localparam int FRAC_BITS = 16;

  // widths that cover the whole supported store depth (up to 65536 pairs)
  localparam int CNT_W = 17;
  localparam int SUM_W = 49;
  localparam int DIV_W = 128;

  // metric codes
  localparam logic [2:0] MET_MAE    = 3'd0;
  localparam logic [2:0] MET_MSE    = 3'd1;
  localparam logic [2:0] MET_MSLE   = 3'd2;
  localparam logic [2:0] MET_MEDIAN = 3'd3;
  localparam logic [2:0] MET_R2     = 3'd4;

  // scaling shifts of the metrics
  localparam int MAE_SHL      = 32 - FRAC_BITS;
  localparam int MSE_SHL      = (32 - 2 * FRAC_BITS > 0) ? 32 - 2 * FRAC_BITS : 0;
  localparam int MSE_SHR      = (2 * FRAC_BITS - 32 > 0) ? 2 * FRAC_BITS - 32 : 0;
  localparam int MED_SHL_ODD  = 32 - FRAC_BITS;
  localparam int MED_SHL_EVEN = 31 - FRAC_BITS;

  // ln(2) in Q.16
  localparam logic [15:0] LN2_Q16 = 16'd45426;

  // log2(1 + i/16) in Q.16
  localparam logic [16:0] LOG2_TAB [17] = '{
    17'd0,     17'd5732,  17'd11136, 17'd16248, 17'd21098, 17'd25711,
    17'd30110, 17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472,
    17'd52911, 17'd56229, 17'd59434, 17'd62534, 17'd65536
  };

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  // one closed set handed from the loader to the scorer
  typedef struct packed {
    cnt_t n;
    logic ovf;
    sum_t sum;
  } rem_job_t;

  // clamp an unsigned quotient to the positive int64 range
  function automatic logic [63:0] sat63(input logic [DIV_W-1:0] q);
    return (q[DIV_W-1:63] != '0) ? 64'h7FFF_FFFF_FFFF_FFFF : q[63:0];
  endfunction

endpackage

/* hw/rtl/rem_if.sv */
// valid/ready channel interfaces of the input pairs and of the scores
interface rem_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] predicted;
  logic signed [31:0] actual;
  logic last_pair;

  modport source(output valid, predicted, actual, last_pair, input ready);
  modport sink(input valid, predicted, actual, last_pair, output ready);
endinterface

interface rem_out_if;
  logic valid;
  logic ready;
  logic signed [63:0] score;
  logic [10:0] pair_count;
  logic overflow;

  modport source(output valid, score, pair_count, overflow, input ready);
  modport sink(input valid, score, pair_count, overflow, output ready);
endinterface

/* hw/rtl/rem_front.sv */
// loader: stores incoming pairs, keeps count and sum, hands closed sets on
module rem_front #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rem_in_if.sink                          in_s,
  output rem_pkg::rem_job_t               job_o,
  output logic                            job_vld_o,
  input  logic                            job_done_i,
  input  logic [$clog2(MAX_SAMPLES)-1:0]  rd_addr_i,
  output logic [63:0]                     rd_data_o
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  logic [63:0] mem [MAX_SAMPLES];
  logic [63:0] rd_data_r;

  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  rem_pkg::sum_t     sum_r, sum_nxt;
  rem_pkg::rem_job_t job_r;
  logic              job_vld_r;

  logic acc;
  logic has_room;

  // one-entry job queue: loading pauses while a set is being scored
  assign in_s.ready = !job_vld_r;
  assign acc        = in_s.valid && in_s.ready;
  assign has_room   = cnt_r < CW'(MAX_SAMPLES);

  // running count, drop flag and sum of actual values
  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    sum_nxt = sum_r;
    if (has_room) begin
      cnt_nxt = cnt_r + CW'(1);
      sum_nxt = sum_r + rem_pkg::sum_t'(in_s.actual);
    end else begin
      ovf_nxt = 1'b1;
    end
  end

  // pair store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (acc && has_room) begin
      mem[cnt_r[AW-1:0]] <= {in_s.predicted, in_s.actual};
    end
    rd_data_r <= mem[rd_addr_i];
  end

  // job payload
  always_ff @(posedge clk) begin
    if (acc && in_s.last_pair) begin
      job_r.n   <= rem_pkg::cnt_t'(cnt_nxt);
      job_r.ovf <= ovf_nxt;
      job_r.sum <= sum_nxt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      sum_r     <= '0;
      job_vld_r <= 1'b0;
    end else begin
      if (job_done_i) begin
        job_vld_r <= 1'b0;
      end
      if (acc) begin
        if (in_s.last_pair) begin
          cnt_r     <= '0;
          ovf_r     <= 1'b0;
          sum_r     <= '0;
          job_vld_r <= 1'b1;
        end else begin
          cnt_r <= cnt_nxt;
          ovf_r <= ovf_nxt;
          sum_r <= sum_nxt;
        end
      end
    end
  end

  assign job_o     = job_r;
  assign job_vld_o = job_vld_r;
  assign rd_data_o = rd_data_r;

endmodule

/* hw/rtl/rem_div.sv */
// restoring divider, one quotient bit per cycle
module rem_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start_i,
  input  logic [rem_pkg::DIV_W-1:0]   num_i,
  input  logic [rem_pkg::DIV_W-1:0]   den_i,
  output logic                        done_o,
  output logic [rem_pkg::DIV_W-1:0]   quo_o
);

  localparam int W  = rem_pkg::DIV_W;
  localparam int NW = $clog2(W);

  logic          busy_r;
  logic          done_r;
  logic [NW-1:0] cnt_r;
  logic [W-1:0]  num_r;
  logic [W-1:0]  den_r;
  logic [W-1:0]  q_r;
  logic [W:0]    rem_r;

  logic [W:0] rem_sh;
  logic       ge;
  logic [W:0] rem_nxt;

  // shift in the next numerator bit and try a subtraction
  always_comb begin
    rem_sh  = {rem_r[W-1:0], num_r[W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? rem_sh - {1'b0, den_r} : rem_sh;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start_i) begin
      num_r <= num_i;
      den_r <= den_i;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      num_r <= {num_r[W-2:0], 1'b0};
      q_r   <= {q_r[W-2:0], ge};
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + NW'(1);
        if (cnt_r == NW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_r;
  assign quo_o  = q_r;

endmodule

/* hw/rtl/rem_back.sv */
// scorer: passes over the stored pairs, divides and drives the result register
module rem_back #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [2:0]                      metric_i,
  input  rem_pkg::rem_job_t               job_i,
  input  logic                            job_vld_i,
  output logic                            job_done_o,
  output logic [$clog2(MAX_SAMPLES)-1:0]  rd_addr_o,
  input  logic [63:0]                     rd_data_i,
  rem_out_if.source                       out_s
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int W  = rem_pkg::DIV_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_PEND = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_MED  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam logic [1:0] TAG_SCORE = 2'd0;
  localparam logic [1:0] TAG_MEAN  = 2'd1;
  localparam logic [1:0] TAG_R2    = 2'd2;

  localparam logic [2:0] PH_ADDR = 3'd0;
  localparam logic [2:0] PH_LOAD = 3'd1;
  localparam logic [2:0] PH_INTP = 3'd2;
  localparam logic [2:0] PH_LN   = 3'd3;
  localparam logic [2:0] PH_DIFF = 3'd4;
  localparam logic [2:0] PH_SQ   = 3'd5;
  localparam logic [2:0] PH_ACC  = 3'd6;

  typedef struct packed {
    logic [16:0] base;
    logic [12:0] diff;
    logic [26:0] frac;
    logic [4:0]  expo;
  } log_prep_t;

  // exponent, table entry and mantissa of log2(1 + max(x, 0))
  function automatic log_prep_t log_prep(input logic [31:0] x);
    logic [31:0] y;
    logic [31:0] m;
    logic [4:0]  msb;
    logic [3:0]  ix;
    log_prep_t   r;
    y   = (x[31] ? 32'd0 : x) + (32'd1 << rem_pkg::FRAC_BITS);
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (y[i]) begin
        msb = 5'(i);
      end
    end
    m      = y << (5'd31 - msb);
    ix     = m[30:27];
    r.base = rem_pkg::LOG2_TAB[{1'b0, ix}];
    r.diff = 13'(rem_pkg::LOG2_TAB[{1'b0, ix} + 5'd1] - rem_pkg::LOG2_TAB[{1'b0, ix}]);
    r.frac = m[26:0];
    r.expo = msb - 5'(rem_pkg::FRAC_BITS);
    return r;
  endfunction

  logic [2:0]        state_r;
  logic [2:0]        ph_r;
  logic [AW-1:0]     idx_r;
  logic              pass2_r;
  logic [1:0]        tag_r;
  logic [W-1:0]      acc_r;
  logic [W-1:0]      res_r;
  logic [W-1:0]      num_r;
  logic [W-1:0]      den_r;
  logic [36:0]       val_r;
  logic [73:0]       sq_r;
  log_prep_t         pp_r, pa_r;
  logic [20:0]       tp_r, ta_r;
  logic [36:0]       lp_r, la_r;
  logic signed [32:0] mean_r;
  logic [5:0]        bit_r;
  logic [32:0]       cand_r;
  logic [32:0]       med1_r;
  logic [CW-1:0]     lt_r;
  logic [CW-1:0]     k_r;
  logic              second_r;
  logic [63:0]       score_r;
  logic              out_vld_r;
  logic [63:0]       out_score_r;
  logic [10:0]       out_cnt_r;
  logic              out_ovf_r;

  logic              div_done;
  logic [W-1:0]      div_quo;

  logic [CW-1:0]     n_w;
  logic              is_last;
  logic signed [33:0] dif;
  logic signed [33:0] dtf;
  logic [32:0]       d_mag;
  logic [32:0]       dt_mag;
  logic [32:0]       trial;
  logic [CW-1:0]     lt_fin;
  logic [32:0]       cand_sel;
  logic [rem_pkg::SUM_W-1:0] sum_mag;
  logic [20:0]       tp_nxt, ta_nxt;
  logic [36:0]       dl;
  logic              load_out;

  rem_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (state_r == S_DIV),
    .num_i   (num_r),
    .den_i   (den_r),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // per-element arithmetic
  always_comb begin
    n_w     = job_i.n[CW-1:0];
    is_last = (CW'(idx_r) + CW'(1)) == n_w;
    dif     = 34'(signed'(rd_data_i[63:32])) - 34'(signed'(rd_data_i[31:0]));
    dtf     = 34'(signed'(rd_data_i[31:0])) - 34'(mean_r);
    d_mag   = dif[33] ? 33'(-dif) : dif[32:0];
    dt_mag  = dtf[33] ? 33'(-dtf) : dtf[32:0];
    trial   = cand_r | (33'd1 << bit_r);
    lt_fin  = lt_r + CW'(d_mag < trial);
    cand_sel = (lt_fin <= k_r) ? trial : cand_r;
    sum_mag = job_i.sum[rem_pkg::SUM_W-1] ? rem_pkg::SUM_W'(-job_i.sum)
                                          : rem_pkg::SUM_W'(job_i.sum);
    tp_nxt  = 21'(pp_r.base) + 21'((40'(pp_r.diff) * 40'(pp_r.frac)) >> 27)
            + (21'(pp_r.expo) << 16);
    ta_nxt  = 21'(pa_r.base) + 21'((40'(pa_r.diff) * 40'(pa_r.frac)) >> 27)
            + (21'(pa_r.expo) << 16);
    dl      = (lp_r > la_r) ? lp_r - la_r : la_r - lp_r;
    load_out = (state_r == S_DONE) && (!out_vld_r || out_s.ready);
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ph_r      <= PH_ADDR;
      pass2_r   <= 1'b0;
      second_r  <= 1'b0;
      tag_r     <= TAG_SCORE;
      out_vld_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_vld_r <= 1'b1;
      end else if (out_s.ready) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (job_vld_i) begin
            idx_r   <= '0;
            ph_r    <= PH_ADDR;
            acc_r   <= '0;
            pass2_r <= 1'b0;
            if (metric_i > rem_pkg::MET_R2 || n_w == '0) begin
              score_r <= '0;
              state_r <= S_DONE;
            end else if (metric_i == rem_pkg::MET_MEDIAN) begin
              bit_r    <= 6'd32;
              cand_r   <= '0;
              lt_r     <= '0;
              second_r <= 1'b0;
              k_r      <= n_w[0] ? (n_w >> 1) : (n_w >> 1) - CW'(1);
              state_r  <= S_MED;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          case (ph_r)
            PH_ADDR: ph_r <= PH_LOAD;
            PH_LOAD: begin
              val_r <= pass2_r ? 37'(dt_mag) : 37'(d_mag);
              pp_r  <= log_prep(rd_data_i[63:32]);
              pa_r  <= log_prep(rd_data_i[31:0]);
              ph_r  <= PH_INTP;
            end
            PH_INTP: begin
              tp_r <= tp_nxt;
              ta_r <= ta_nxt;
              ph_r <= PH_LN;
            end
            PH_LN: begin
              lp_r <= 37'(tp_r) * 37'(rem_pkg::LN2_Q16);
              la_r <= 37'(ta_r) * 37'(rem_pkg::LN2_Q16);
              ph_r <= PH_DIFF;
            end
            PH_DIFF: begin
              if (metric_i == rem_pkg::MET_MSLE && !pass2_r) begin
                val_r <= dl;
              end
              ph_r <= PH_SQ;
            end
            PH_SQ: begin
              sq_r <= 74'(val_r) * 74'(val_r);
              ph_r <= PH_ACC;
            end
            default: begin
              acc_r <= acc_r + ((metric_i == rem_pkg::MET_MAE && !pass2_r) ?
                                W'(val_r) : W'(sq_r));
              ph_r  <= PH_ADDR;
              if (is_last) begin
                state_r <= S_PEND;
              end else begin
                idx_r <= idx_r + AW'(1);
              end
            end
          endcase
        end
        S_PEND: begin
          state_r <= S_DIV;
          if (pass2_r) begin
            if (acc_r == '0) begin
              score_r <= 64'h1_0000_0000;
              state_r <= S_DONE;
            end else begin
              num_r <= res_r << 32;
              den_r <= acc_r;
              tag_r <= TAG_R2;
            end
          end else if (metric_i == rem_pkg::MET_R2) begin
            res_r <= acc_r;
            num_r <= W'(sum_mag);
            den_r <= W'(n_w);
            tag_r <= TAG_MEAN;
          end else begin
            case (metric_i)
              rem_pkg::MET_MAE: num_r <= acc_r << rem_pkg::MAE_SHL;
              rem_pkg::MET_MSE: num_r <= acc_r << rem_pkg::MSE_SHL;
              default:          num_r <= acc_r;
            endcase
            den_r <= W'(n_w);
            tag_r <= TAG_SCORE;
          end
        end
        S_DIV: state_r <= S_WAIT;
        S_WAIT: begin
          if (div_done) begin
            case (tag_r)
              TAG_MEAN: begin
                mean_r  <= job_i.sum[rem_pkg::SUM_W-1] ? -signed'(div_quo[32:0])
                                                       : signed'(div_quo[32:0]);
                pass2_r <= 1'b1;
                acc_r   <= '0;
                idx_r   <= '0;
                ph_r    <= PH_ADDR;
                state_r <= S_SCAN;
              end
              TAG_R2: begin
                if (div_quo > W'(64'h8000_0001_0000_0000)) begin
                  score_r <= 64'h8000_0000_0000_0000;
                end else begin
                  score_r <= 64'h1_0000_0000 - div_quo[63:0];
                end
                state_r <= S_DONE;
              end
              default: begin
                case (metric_i)
                  rem_pkg::MET_MSE:
                    score_r <= 64'd0 - rem_pkg::sat63(div_quo >> rem_pkg::MSE_SHR);
                  rem_pkg::MET_MSLE:
                    score_r <= 64'd0 - rem_pkg::sat63(div_quo >> 32);
                  default:
                    score_r <= 64'd0 - rem_pkg::sat63(div_quo);
                endcase
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_MED: begin
          // one bit of the order statistic per pass: count errors below the trial
          if (ph_r == PH_ADDR) begin
            ph_r <= PH_LOAD;
          end else begin
            ph_r <= PH_ADDR;
            if (!is_last) begin
              lt_r  <= lt_fin;
              idx_r <= idx_r + AW'(1);
            end else begin
              idx_r <= '0;
              lt_r  <= '0;
              if (bit_r != 6'd0) begin
                cand_r <= cand_sel;
                bit_r  <= bit_r - 6'd1;
              end else if (n_w[0]) begin
                score_r <= 64'd0 - (64'(cand_sel) << rem_pkg::MED_SHL_ODD);
                state_r <= S_DONE;
              end else if (!second_r) begin
                med1_r   <= cand_sel;
                second_r <= 1'b1;
                cand_r   <= '0;
                bit_r    <= 6'd32;
                k_r      <= k_r + CW'(1);
              end else begin
                score_r <= 64'd0 - ((64'(med1_r) + 64'(cand_sel)) << rem_pkg::MED_SHL_EVEN);
                state_r <= S_DONE;
              end
            end
          end
        end
        S_DONE: begin
          if (load_out) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_score_r <= score_r;
      out_cnt_r   <= 11'(job_i.n);
      out_ovf_r   <= job_i.ovf;
    end
  end

  assign job_done_o       = load_out;
  assign rd_addr_o        = idx_r;
  assign out_s.valid      = out_vld_r;
  assign out_s.score      = out_score_r;
  assign out_s.pair_count = out_cnt_r;
  assign out_s.overflow   = out_ovf_r;

endmodule

/* hw/rtl/regression_error_metric_core.sv */
// top level of the regression error metric block
// Usage:
//   in_s carries (predicted, actual, last_pair) transactions in signed Q16.16.
//   Pairs are taken one per cycle while in_s.ready is high and written to
//   the pair store. A transaction with last_pair set closes the set;
//   in_s.ready then stays low until the set's score is in the result register.
//   out_s carries one transaction per set: score in signed Q32.32, pair_count
//   and overflow (pairs beyond MAX_SAMPLES were dropped).
//   cfg_* is an APB write/read port; register 0 (byte address 0) holds
//   metric_select: 0 -MAE, 1 -MSE, 2 -MSLE, 3 -median AE, 4 R2.
// Work after the closing pair: -MAE, -MSE and -MSLE make one pass over the
// store (address, load, interpolate, ln, difference, square and accumulate
// per pair) and one divide; R2 makes two passes and two divides; -median
// makes one pass per bit of the 33-bit absolute error, twice for even n.
// A stalled out_s keeps the result register; the next set may load meanwhile.
// Reset (rst_n low, synchronous) empties the store and sets metric_select to 0.
module regression_error_metric_core #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  rem_in_if.sink      in_s,
  rem_out_if.source   out_s,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic REG_METRIC = 1'b0;

  logic [2:0]                  metric_r;
  rem_pkg::rem_job_t           job;
  logic                        job_vld;
  logic                        job_done;
  logic [$clog2(MAX_SAMPLES)-1:0] rd_addr;
  logic [63:0]                 rd_data;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r <= rem_pkg::MET_MAE;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_METRIC) begin
      metric_r <= cfg_pwdata[2:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_METRIC) ? {29'd0, metric_r} : 32'd0;

  rem_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_s       (in_s),
    .job_o      (job),
    .job_vld_o  (job_vld),
    .job_done_i (job_done),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data)
  );

  rem_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .metric_i   (metric_r),
    .job_i      (job),
    .job_vld_i  (job_vld),
    .job_done_o (job_done),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .out_s      (out_s)
  );

endmodule
